FILE: rtl/c_token_scanner_with_symbol_table_defines.svh
// assertion macros used by the scanner rtl
`ifndef C_TOKEN_SCANNER_WITH_SYMBOL_TABLE_DEFINES_SVH
`define C_TOKEN_SCANNER_WITH_SYMBOL_TABLE_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define CTSS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CTSS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/ctss_pkg.sv
// types, codes and keyword table for the token scanner
package ctss_pkg;

  localparam int MAX_TOKEN_CHARS_DEF = 8;
  localparam int SYMBOL_DEPTH_DEF    = 32;
  localparam int KEYWORD_COUNT_DEF   = 24;
  localparam int KW_TABLE_SIZE       = 24;
  localparam int QDEPTH              = 4;

  localparam logic [2:0] KIND_KEYWORD  = 3'd0;
  localparam logic [2:0] KIND_IDENT    = 3'd1;
  localparam logic [2:0] KIND_NUMBER   = 3'd2;
  localparam logic [2:0] KIND_RELOP    = 3'd3;
  localparam logic [2:0] KIND_OTHER    = 3'd4;
  localparam logic [2:0] KIND_INVALID  = 3'd5;
  localparam logic [2:0] KIND_UNCLOSED = 3'd6;

  localparam logic [2:0] RELOP_LT = 3'd0;
  localparam logic [2:0] RELOP_GT = 3'd2;
  localparam logic [2:0] RELOP_EQ = 3'd4;
  localparam logic [2:0] RELOP_NE = 3'd5;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [2:0] {
    S_IDLE, S_IDENT, S_NUMBER, S_ANGLE, S_EQNOT, S_SLASH, S_COMMENT, S_STAR
  } scan_t;

  typedef enum logic [1:0] {B_IDLE, B_SEARCH, B_RESULT} bst_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] text;
    logic [3:0]  len;
    logic [2:0]  relop;
    logic        trunc;
    logic        last;
  } tok_t;

  localparam logic [63:0] KW_TABLE [KW_TABLE_SIZE] = '{
    64'h746E69, 64'h656C696877, 64'h6B61657262, 64'h726F66, 64'h6F64, 64'h6669,
    64'h74616F6C66, 64'h72616863, 64'h686374697773, 64'h656C62756F64,
    64'h74726F6873, 64'h676E6F6C, 64'h64656E6769736E75, 64'h666F657A6973,
    64'h65736C65, 64'h7265747369676572, 64'h6E7265747865, 64'h636974617473,
    64'h6F747561, 64'h65736163, 64'h6B61657262, 64'h656C6974616C6F76,
    64'h6D756E65, 64'h66656465707974
  };

  function automatic logic is_keyword(logic [63:0] text, int kcount);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < KW_TABLE_SIZE; i++) begin
      if (i < kcount && KW_TABLE[i] == text) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

FILE: rtl/ctss_ram.sv
// generic single write port ram with registered read
module ctss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/ctss_front.sv
// character scanner: classifies bytes and builds pending tokens
module ctss_front import ctss_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       end_of_input,
  output logic [1:0] emit_n,
  output tok_t       tok0,
  output tok_t       tok1
);

  scan_t       st, st_next;
  logic [63:0] buff, buff_next;
  logic [3:0]  cnt, cnt_next;
  logic        ovf, ovf_next;
  logic [7:0]  foc, foc_next;
  tok_t        tk [2];

  always_comb begin
    logic       go;
    logic [1:0] ne;
    logic [2:0] code;
    logic       eq;
    ne   = 2'd0;
    go   = 1'b1;
    code = RELOP_LT;
    eq   = 1'b0;
    st_next   = st;
    buff_next = buff;
    cnt_next  = cnt;
    ovf_next  = ovf;
    foc_next  = foc;
    tk[0] = '0;
    tk[1] = '0;
    if (end_of_input) begin
      unique case (st)
        S_IDENT: begin
          tk[0] = '{KIND_IDENT, buff, cnt, 3'd0, ovf, 1'b0};
          ne = 2'd1;
        end
        S_NUMBER: begin
          tk[0] = '{KIND_NUMBER, buff, cnt, 3'd0, ovf, 1'b0};
          ne = 2'd1;
        end
        S_ANGLE: begin
          tk[0] = '{KIND_RELOP, {56'd0, foc}, 4'd1,
                    (foc == CH_LT) ? RELOP_LT : RELOP_GT, 1'b0, 1'b0};
          ne = 2'd1;
        end
        S_SLASH: begin
          tk[0] = '{KIND_INVALID, {56'd0, CH_SLASH}, 4'd1, 3'd0, 1'b0, 1'b0};
          ne = 2'd1;
        end
        S_COMMENT, S_STAR: begin
          tk[0] = '{KIND_UNCLOSED, 64'd0, 4'd0, 3'd0, 1'b0, 1'b0};
          ne = 2'd1;
        end
        default: ;
      endcase
      st_next   = S_IDLE;
      foc_next  = 8'd0;
      buff_next = 64'd0;
      cnt_next  = 4'd0;
      ovf_next  = 1'b0;
    end else begin
      // a character that closes a token is scanned once more from idle
      for (int p = 0; p < 2; p++) begin
        if (go) begin
          go = 1'b0;
          unique case (st_next)
            S_IDLE: begin
              if (is_letter(char_code) || is_digit(char_code)) begin
                buff_next = {56'd0, char_code};
                cnt_next  = 4'd1;
                ovf_next  = 1'b0;
                st_next   = is_letter(char_code) ? S_IDENT : S_NUMBER;
              end else if (char_code == CH_LT || char_code == CH_GT) begin
                foc_next = char_code;
                st_next  = S_ANGLE;
              end else if (char_code == CH_EQ || char_code == CH_BANG) begin
                foc_next = char_code;
                st_next  = S_EQNOT;
              end else if (char_code == CH_SLASH) begin
                st_next = S_SLASH;
              end else if (char_code == CH_SPACE || char_code == CH_TAB ||
                           char_code == CH_NL) begin
              end else begin
                tk[ne[0]] = '{KIND_OTHER, {56'd0, char_code}, 4'd1, 3'd0, 1'b0, 1'b0};
                ne = ne + 2'd1;
              end
            end
            S_IDENT, S_NUMBER: begin
              if (is_digit(char_code) ||
                  (st_next == S_IDENT && is_letter(char_code))) begin
                if (cnt_next < 4'(MAX_TOKEN_CHARS)) begin
                  buff_next = buff_next | (64'(char_code) << {cnt_next[2:0], 3'b000});
                  cnt_next  = cnt_next + 4'd1;
                end else begin
                  ovf_next = 1'b1;
                end
              end else begin
                tk[ne[0]] = '{(st_next == S_IDENT) ? KIND_IDENT : KIND_NUMBER,
                              buff_next, cnt_next, 3'd0, ovf_next, 1'b0};
                ne = ne + 2'd1;
                buff_next = 64'd0;
                cnt_next  = 4'd0;
                ovf_next  = 1'b0;
                st_next   = S_IDLE;
                go        = 1'b1;
              end
            end
            S_ANGLE, S_EQNOT: begin
              eq = (char_code == CH_EQ);
              priority if (foc_next == CH_LT) code = RELOP_LT;
              else if (foc_next == CH_GT)     code = RELOP_GT;
              else if (foc_next == CH_EQ)     code = RELOP_EQ;
              else                            code = RELOP_NE;
              if (eq && code < RELOP_EQ) code = code + 3'd1;
              if (st_next == S_ANGLE || eq) begin
                tk[ne[0]] = '{KIND_RELOP,
                              eq ? {48'd0, CH_EQ, foc_next} : {56'd0, foc_next},
                              eq ? 4'd2 : 4'd1, code, 1'b0, 1'b0};
                ne = ne + 2'd1;
              end
              foc_next = 8'd0;
              st_next  = S_IDLE;
              go       = !eq;
            end
            S_SLASH: begin
              if (char_code == CH_STAR) begin
                st_next = S_COMMENT;
              end else begin
                tk[ne[0]] = '{KIND_INVALID, {56'd0, CH_SLASH}, 4'd1, 3'd0, 1'b0, 1'b0};
                ne = ne + 2'd1;
                st_next = S_IDLE;
                go      = 1'b1;
              end
            end
            S_COMMENT: begin
              if (char_code == CH_STAR) st_next = S_STAR;
            end
            S_STAR: begin
              if (char_code == CH_SLASH) st_next = S_IDLE;
              else if (char_code != CH_STAR) st_next = S_COMMENT;
            end
          endcase
        end
      end
    end
    if (ne == 2'd1) tk[0].last = 1'b1;
    if (ne == 2'd2) tk[1].last = 1'b1;
    emit_n = ne;
    tok0   = tk[0];
    tok1   = tk[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      buff <= 64'd0;
      cnt  <= 4'd0;
      ovf  <= 1'b0;
      foc  <= 8'd0;
    end else if (accept) begin
      st   <= st_next;
      buff <= buff_next;
      cnt  <= cnt_next;
      ovf  <= ovf_next;
      foc  <= foc_next;
    end
  end

endmodule

FILE: rtl/ctss_queue.sv
// short token queue between scanner and lookup, up to two pushes a cycle
module ctss_queue import ctss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_n,
  input  tok_t       tok0,
  input  tok_t       tok1,
  input  logic       pop,
  output tok_t       head,
  output logic       nonempty,
  output logic       room
);

  localparam int PW = $clog2(QDEPTH);

  tok_t            mem [QDEPTH];
  logic [PW-1:0]   wp, rp;
  logic [PW:0]     count;

  assign head     = mem[rp];
  assign nonempty = (count != '0);
  assign room     = (count <= (PW+1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp] <= tok0;
    if (push_n == 2'd2) mem[wp + PW'(1)] <= tok1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PW'(push_n);
      rp    <= rp + PW'(pop);
      count <= count + (PW+1)'(push_n) - (PW+1)'(pop);
    end
  end

endmodule

FILE: rtl/ctss_back.sv
// symbol lookup and insert, result register
`include "c_token_scanner_with_symbol_table_defines.svh"
module ctss_back import ctss_pkg::*; #(
  parameter int SYMBOL_DEPTH  = SYMBOL_DEPTH_DEF,
  parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  tok_t        head,
  input  logic        nonempty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [63:0] token_text,
  output logic [3:0]  token_length,
  output logic [2:0]  relop_code,
  output logic        was_truncated,
  output logic [4:0]  symbol_index,
  output logic        symbol_new,
  output logic        store_full,
  output logic        last_result
);

  localparam int AW = (SYMBOL_DEPTH > 1) ? $clog2(SYMBOL_DEPTH) : 1;
  localparam int CW = $clog2(SYMBOL_DEPTH + 1);

  bst_t          bst, bst_next;
  tok_t          cur;
  logic [AW-1:0] sidx, fidx;
  logic          found;
  logic [CW-1:0] scount;
  logic [63:0]   rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic          out_free;
  logic          take_plain, take_name, finish;
  logic          hit, last_cmp;

  assign out_free = !out_valid || !out_stall;
  assign hit      = (rdata == cur.text);
  assign last_cmp = (CW'(sidx) + CW'(1) == scount);
  assign raddr    = (bst == B_SEARCH) ? AW'(CW'(sidx) + CW'(1)) : '0;

  ctss_ram #(.WIDTH(64), .DEPTH(SYMBOL_DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(scount)),
    .wdata (cur.text),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    bst_next = bst;
    unique case (bst)
      B_IDLE: begin
        if (nonempty && head.kind == KIND_IDENT)
          bst_next = (scount == '0) ? B_RESULT : B_SEARCH;
      end
      B_SEARCH: begin
        if (hit || last_cmp) bst_next = B_RESULT;
      end
      B_RESULT: begin
        if (out_free) bst_next = B_IDLE;
      end
      default: bst_next = B_IDLE;
    endcase
  end

  always_comb begin
    take_plain = (bst == B_IDLE) && nonempty && head.kind != KIND_IDENT && out_free;
    take_name  = (bst == B_IDLE) && nonempty && head.kind == KIND_IDENT;
    finish     = (bst == B_RESULT) && out_free;
    pop        = take_plain || take_name;
    we         = finish && !found && (scount < CW'(SYMBOL_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (take_name) cur <= head;
    if (take_name) begin
      sidx  <= '0;
      found <= 1'b0;
    end else if (bst == B_SEARCH) begin
      if (hit) begin
        found <= 1'b1;
        fidx  <= sidx;
      end else begin
        sidx <= sidx + AW'(1);
      end
    end
    if (take_plain) begin
      token_kind    <= head.kind;
      token_text    <= head.text;
      token_length  <= head.len;
      relop_code    <= head.relop;
      was_truncated <= head.trunc;
      symbol_index  <= 5'd0;
      symbol_new    <= 1'b0;
      store_full    <= 1'b0;
      last_result   <= head.last;
    end else if (finish) begin
      token_kind    <= (!cur.trunc && is_keyword(cur.text, KEYWORD_COUNT)) ?
                       KIND_KEYWORD : KIND_IDENT;
      token_text    <= cur.text;
      token_length  <= cur.len;
      relop_code    <= 3'd0;
      was_truncated <= cur.trunc;
      symbol_index  <= found ? 5'(fidx) : (we ? 5'(scount) : 5'd0);
      symbol_new    <= we;
      store_full    <= !found && !we;
      last_result   <= cur.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bst       <= B_IDLE;
      scount    <= '0;
      out_valid <= 1'b0;
    end else begin
      bst <= bst_next;
      if (we) scount <= scount + CW'(1);
      if (take_plain || finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  `CTSS_ASSERT(a_count_bound, scount <= CW'(SYMBOL_DEPTH), "symbol count past depth")
  `CTSS_IMPLY(a_new_not_full, out_valid && symbol_new, !store_full, "new and full together")
  `CTSS_IMPLY(a_search_range, bst == B_SEARCH, CW'(sidx) < scount, "search past filled slots")

endmodule

FILE: rtl/c_token_scanner_with_symbol_table.sv
// top level: token scanner with symbol store
//
// channel  signals                          request
// in       in_valid / in_stall              char_code, end_of_input
// out      out_valid / out_stall            one token with lookup fields
//
// the scanner takes one character per cycle while the token queue has room for two
// an identifier or keyword is looked up by a linear search over the filled store slots,
// through the one read port of the symbol ram; other tokens go straight to the result register
// an item that gives two tokens puts both in the queue in the same cycle
// rst is synchronous; the symbol store needs no clearing, only filled slots are compared
// out_stall holds the result register; in_stall rises when the queue is nearly full
module c_token_scanner_with_symbol_table import ctss_pkg::*; #(
  parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF,
  parameter int SYMBOL_DEPTH    = SYMBOL_DEPTH_DEF,
  parameter int KEYWORD_COUNT   = KEYWORD_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  token_kind,
  output logic [63:0] token_text,
  output logic [3:0]  token_length,
  output logic [2:0]  relop_code,
  output logic        was_truncated,
  output logic [4:0]  symbol_index,
  output logic        symbol_new,
  output logic        store_full,
  output logic        last_result
);

  logic       accept, room, nonempty, pop;
  logic [1:0] emit_n;
  tok_t       tok0, tok1, head;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  ctss_front #(.MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .emit_n       (emit_n),
    .tok0         (tok0),
    .tok1         (tok1)
  );

  ctss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_n   (accept ? emit_n : 2'd0),
    .tok0     (tok0),
    .tok1     (tok1),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty),
    .room     (room)
  );

  ctss_back #(.SYMBOL_DEPTH(SYMBOL_DEPTH), .KEYWORD_COUNT(KEYWORD_COUNT)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .nonempty      (nonempty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_kind    (token_kind),
    .token_text    (token_text),
    .token_length  (token_length),
    .relop_code    (relop_code),
    .was_truncated (was_truncated),
    .symbol_index  (symbol_index),
    .symbol_new    (symbol_new),
    .store_full    (store_full),
    .last_result   (last_result)
  );

endmodule
